>>> rtl/mad_pkg.sv
package mad_pkg;

    // Default sizes
    localparam int ARRAYS_DEF     = 64;
    localparam int MAX_DIMS_DEF   = 16;
    localparam int ADDR_WIDTH_DEF = 32;

    // Multiplier digit width (bits of the second operand per cycle)
    localparam int DIGIT_W = 16;

    // Beat opcodes
    typedef enum logic [1:0] {
        MODE_DEFINE = 2'd0,
        MODE_BOUNDS = 2'd1,
        MODE_INDEX  = 2'd2
    } mode_t;

    // Input beat
    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         array_id;
        logic signed [31:0] base;
        logic [15:0]        elem_size;
        logic [4:0]         dims;
        logic [4:0]         dim_index;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic signed [31:0] index_value;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [31:0] address;
        logic [5:0]         result_array;
    } out_beat_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MAC,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Multiplier command
    typedef struct packed {
        logic start;
        logic single;   // one digit only (element size multiply)
    } mul_ctrl_t;

    // Reduce a 6-bit id modulo n by restoring compare-subtract steps
    function automatic logic [5:0] id_reduce(logic [5:0] v, int n);
        int r;
        r = int'(v);
        for (int k = 5; k >= 0; k--) begin
            if (r >= (n << k)) begin
                r = r - (n << k);
            end
        end
        return 6'(r);
    endfunction

endpackage

>>> rtl/mad_ram.sv
module mad_ram #(
    parameter int WIDTH  = mad_pkg::ADDR_WIDTH_DEF,
    parameter int DEPTH  = mad_pkg::ARRAYS_DEF,
    parameter int ADDR_W = $clog2(mad_pkg::ARRAYS_DEF)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mad_mul.sv
module mad_mul #(
    parameter int ADDR_WIDTH = mad_pkg::ADDR_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mad_pkg::mul_ctrl_t    ctrl,
    input  logic [ADDR_WIDTH-1:0] op_a,
    input  logic [ADDR_WIDTH-1:0] op_b,
    output logic                  done,
    output logic [ADDR_WIDTH-1:0] product
);

    localparam int DW    = mad_pkg::DIGIT_W;
    localparam int NDIG  = (ADDR_WIDTH + DW - 1) / DW;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [ADDR_WIDTH-1:0] a_reg;
    logic [ADDR_WIDTH-1:0] b_reg;
    logic [ADDR_WIDTH-1:0] p_reg;
    logic [CNT_W-1:0]      left_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Digit counter and status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                left_reg <= ctrl.single ? CNT_W'(1) : CNT_W'(NDIG);
            end else if (busy_reg) begin
                left_reg <= left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-and-accumulate datapath, one digit of op_b per cycle, low bits kept
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            a_reg <= op_a;
            b_reg <= op_b;
            p_reg <= '0;
        end else if (busy_reg) begin
            p_reg <= p_reg + ADDR_WIDTH'(a_reg * b_reg[DW-1:0]);
            a_reg <= a_reg << DW;
            b_reg <= b_reg >> DW;
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

>>> rtl/multidim_array_address.sv
// Row-major array address generator. A descriptor memory holds base, element
// size and dimension count per array; a bounds memory holds lower bound and
// extent per (array, dimension). Define and bound beats are written from the
// idle state. An index beat first reads the bounds memory, then the shared
// 16-bit-digit multiplier forms acc * extent one digit per cycle before the
// add. The last index of a query goes on to a one-digit multiply by element
// size, the base add and the load of the output register, plus any wait for
// the output register to drain. Descriptors and bounds come out of reset
// undefined and must be written before they are used; there is no clearing
// pass.
module multidim_array_address #(
    parameter int ARRAYS     = mad_pkg::ARRAYS_DEF,
    parameter int MAX_DIMS   = mad_pkg::MAX_DIMS_DEF,
    parameter int ADDR_WIDTH = mad_pkg::ADDR_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mad_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mad_pkg::out_beat_t m_data
);

    localparam int IDX_W  = (ARRAYS > 1) ? $clog2(ARRAYS) : 1;
    localparam int DIM_W  = $clog2(MAX_DIMS + 1);
    localparam int SLOTS  = ARRAYS * MAX_DIMS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SIZE_W = 16;
    localparam int DESC_W = ADDR_WIDTH + SIZE_W + DIM_W;
    localparam int BND_W  = 2 * ADDR_WIDTH;

    mad_pkg::state_t       state_reg, state_next;
    logic [ADDR_WIDTH-1:0] acc_reg, acc_next;
    logic [DIM_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      query_reg, query_next;
    logic [ADDR_WIDTH-1:0] idx_reg, idx_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic                  m_valid_reg, m_valid_next;
    mad_pkg::out_beat_t    m_data_reg, m_data_next;

    logic [IDX_W-1:0]      in_id;
    logic [IDX_W-1:0]      qid;
    logic [DIM_W-1:0]      dims_clamped;
    logic [DIM_W-1:0]      cnt_c;
    logic [DIM_W-1:0]      cnt_inc;
    logic                  di_ok;
    logic                  out_free;
    logic [ADDR_WIDTH-1:0] in_lower;
    logic [ADDR_WIDTH-1:0] in_upper;
    logic [ADDR_WIDTH-1:0] sum;

    logic                  desc_we;
    logic                  bnd_we;
    logic                  rd_en;
    logic [SLOT_W-1:0]     bnd_wr_addr;
    logic [SLOT_W-1:0]     bnd_rd_addr;
    logic [DESC_W-1:0]     desc_wr_data;
    logic [DESC_W-1:0]     desc_rd_data;
    logic [BND_W-1:0]      bnd_wr_data;
    logic [BND_W-1:0]      bnd_rd_data;
    logic [ADDR_WIDTH-1:0] desc_base;
    logic [SIZE_W-1:0]     desc_size;
    logic [DIM_W-1:0]      desc_dims;
    logic [ADDR_WIDTH-1:0] bnd_lower;
    logic [ADDR_WIDTH-1:0] bnd_extent;

    mad_pkg::mul_ctrl_t    mul_ctrl;
    logic [ADDR_WIDTH-1:0] mul_a;
    logic [ADDR_WIDTH-1:0] mul_b;
    logic                  mul_done;
    logic [ADDR_WIDTH-1:0] mul_product;

    // Field decode of the input beat
    always_comb begin
        in_id = IDX_W'(mad_pkg::id_reduce(s_data.array_id, ARRAYS));
        if (s_data.dims == 5'd0) begin
            dims_clamped = DIM_W'(1);
        end else if (int'(s_data.dims) > MAX_DIMS) begin
            dims_clamped = DIM_W'(MAX_DIMS);
        end else begin
            dims_clamped = DIM_W'(s_data.dims);
        end
        di_ok    = (s_data.dim_index != 5'd0) && (int'(s_data.dim_index) <= MAX_DIMS);
        in_lower = ADDR_WIDTH'(s_data.lower);
        in_upper = ADDR_WIDTH'(s_data.upper);
        qid      = (cnt_reg == '0) ? in_id : query_reg;
        cnt_c    = (int'(cnt_reg) >= MAX_DIMS) ? DIM_W'(MAX_DIMS - 1) : cnt_reg;
        cnt_inc  = cnt_c + DIM_W'(1);
    end

    // Memory addresses and write data
    assign bnd_wr_addr  = SLOT_W'(int'(in_id) * MAX_DIMS + int'(s_data.dim_index) - 1);
    assign bnd_rd_addr  = SLOT_W'(int'(qid) * MAX_DIMS + int'(cnt_c));
    assign desc_wr_data = {ADDR_WIDTH'(s_data.base), s_data.elem_size, dims_clamped};
    assign bnd_wr_data  = {in_upper - in_lower + ADDR_WIDTH'(1), in_lower};
    assign {desc_base, desc_size, desc_dims} = desc_rd_data;
    assign {bnd_extent, bnd_lower}           = bnd_rd_data;

    mad_ram #(
        .WIDTH  (DESC_W),
        .DEPTH  (ARRAYS),
        .ADDR_W (IDX_W)
    ) u_desc_ram (
        .aclk    (aclk),
        .wr_en   (desc_we),
        .wr_addr (in_id),
        .wr_data (desc_wr_data),
        .rd_en   (rd_en),
        .rd_addr (qid),
        .rd_data (desc_rd_data)
    );

    mad_ram #(
        .WIDTH  (BND_W),
        .DEPTH  (SLOTS),
        .ADDR_W (SLOT_W)
    ) u_bnd_ram (
        .aclk    (aclk),
        .wr_en   (bnd_we),
        .wr_addr (bnd_wr_addr),
        .wr_data (bnd_wr_data),
        .rd_en   (rd_en),
        .rd_addr (bnd_rd_addr),
        .rd_data (bnd_rd_data)
    );

    mad_mul #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer: next state and datapath control
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        query_next   = query_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        desc_we      = 1'b0;
        bnd_we       = 1'b0;
        rd_en        = 1'b0;
        mul_ctrl     = '0;
        mul_a        = acc_reg;
        mul_b        = bnd_extent;
        sum          = mul_product + (idx_reg - bnd_lower);

        case (state_reg)
            mad_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (mad_pkg::mode_t'(s_data.mode))
                        mad_pkg::MODE_DEFINE: begin
                            desc_we  = 1'b1;
                            acc_next = '0;
                            cnt_next = '0;
                        end
                        mad_pkg::MODE_BOUNDS: begin
                            bnd_we   = di_ok;
                            acc_next = '0;
                            cnt_next = '0;
                        end
                        mad_pkg::MODE_INDEX: begin
                            rd_en      = 1'b1;
                            query_next = qid;
                            idx_next   = ADDR_WIDTH'(s_data.index_value);
                            state_next = mad_pkg::ST_START;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mad_pkg::ST_START: begin
                // bounds read data is now valid: acc * extent
                mul_ctrl.start = 1'b1;
                state_next     = mad_pkg::ST_MAC;
            end
            mad_pkg::ST_MAC: begin
                if (mul_done) begin
                    if (cnt_inc >= desc_dims) begin
                        // last subscript: scale by element size
                        mul_ctrl.start  = 1'b1;
                        mul_ctrl.single = 1'b1;
                        mul_a           = sum;
                        mul_b           = ADDR_WIDTH'(desc_size);
                        acc_next        = '0;
                        cnt_next        = '0;
                        state_next      = mad_pkg::ST_SCALE;
                    end else begin
                        acc_next   = sum;
                        cnt_next   = cnt_inc;
                        state_next = mad_pkg::ST_IDLE;
                    end
                end
            end
            mad_pkg::ST_SCALE: begin
                if (mul_done) begin
                    addr_next  = desc_base + mul_product;
                    state_next = mad_pkg::ST_EMIT;
                end
            end
            mad_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.address       = 32'(addr_reg);
                    m_data_next.result_array  = 6'(query_reg);
                    state_next                = mad_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mad_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mad_pkg::ST_IDLE;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            query_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            query_reg   <= query_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    // multiplier only finishes while the sequencer waits on it
    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == mad_pkg::ST_MAC || state_reg == mad_pkg::ST_SCALE))
        else $error("multiplier done outside a wait state");

    // dimension counter stays below the dimension limit
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) < MAX_DIMS)
        else $error("dimension counter out of range");

    // an accepted index beat starts a table read and multiply
    a_index_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == mad_pkg::MODE_INDEX)
        |=> state_reg == mad_pkg::ST_START)
        else $error("index beat did not start the multiply");

    // a finished address is loaded once the output register is free
    a_emit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mad_pkg::ST_EMIT && out_free) |=> m_valid_reg)
        else $error("result not loaded into output register");

    // no input beat accepted while a query step is in flight
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == mad_pkg::ST_IDLE && !mul_done))
        else $error("input ready while busy");
`endif

endmodule
